@@ design/pcfm_pkg.sv @@
package pcfm_pkg;

  localparam int unsigned MAX_TAPS_DEF = 32;
  localparam int unsigned TAP_COUNT_W = 6;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 6'd32;

  // The trig table covers one octant plus its end point.
  localparam int unsigned TRIG_ENTRIES = 513;
  localparam int unsigned TRIG_ADDR_W = 10;
  localparam int unsigned MAG_W = 15;

  typedef enum logic [0:0] {
    OP_TAP_WRITE = 1'b0,
    OP_CHIP      = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [4:0]         tap_index;
    logic signed [15:0] tap_value;
    logic [15:0]        code_phase;
    logic               last_chip;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] in_phase;
    logic signed [15:0] quadrature;
    logic               last_of_chip;
    logic               last_of_pulse;
  } out_item_t;

  // Upper half holds the cosine magnitude, lower half the sine magnitude.
  typedef logic [2*MAG_W-1:0] trig_tbl_t [TRIG_ENTRIES];

  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI_STEP = PI_Q60 / 2048;
  localparam logic [63:0] PI_FRAC = PI_Q60 % 2048;

  localparam logic [63:0] COS_DIV [14] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };
  localparam logic [63:0] SIN_DIV [14] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [MAG_W-1:0] scale_mag(logic [63:0] v);
    logic [63:0] t;
    t = (v >> 20) * 64'd32767;
    t = (t + (64'd1 << 39)) >> 40;
    return t[MAG_W-1:0];
  endfunction

  // Taylor series in Q60, evaluated at elaboration to fill the table.
  function automatic trig_tbl_t build_trig_table();
    trig_tbl_t  tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] tc;
    logic [63:0] ts;
    logic [63:0] sc;
    logic [63:0] ss;
    for (int r = 0; r < TRIG_ENTRIES; r++) begin
      x  = PI_STEP * 64'(r) + ((PI_FRAC * 64'(r)) >> 11);
      x2 = mul_q60(x, x);
      tc = ONE_Q60;
      ts = x;
      sc = ONE_Q60;
      ss = x;
      for (int k = 0; k < 14; k++) begin
        tc = mul_q60(tc, x2) / COS_DIV[k];
        ts = mul_q60(ts, x2) / SIN_DIV[k];
        if ((k % 2) == 0) begin
          sc = sc - tc;
          ss = ss - ts;
        end else begin
          sc = sc + tc;
          ss = ss + ts;
        end
      end
      tbl[r] = {scale_mag(sc), scale_mag(ss)};
    end
    return tbl;
  endfunction

endpackage

@@ design/pcfm_waveform_generator_unit.sv @@
// A chip's first sample is formed through registers s1 to s4 and then the output register.
// Throughput: one sample per cycle unless the output stalls; a chip occupies the tap
// sequencer until its final tap read, and the next item is taken in the cycle of that read.
// The tap store's single read port gives one tap per cycle unless stalled and sets the rate.
// Reset is asynchronous and active low; it clears control, phase and accumulator and restores
// the tap count to 32. The tap store is not cleared.
module pcfm_waveform_generator_unit #(
  parameter int unsigned MAX_TAPS = pcfm_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pcfm_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pcfm_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcfm_pkg::TAP_COUNT_W-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW  = pcfm_pkg::TAP_COUNT_W + 1;
  localparam pcfm_pkg::trig_tbl_t TrigRom = pcfm_pkg::build_trig_table();

  // Configuration and sequencer state.
  logic [pcfm_pkg::TAP_COUNT_W-1:0] tap_count_q;
  logic                 busy_q, busy_d;
  logic [AddrW-1:0]     tap_idx_q, tap_idx_d;
  logic [AddrW-1:0]     last_idx_q;
  logic                 last_chip_q;
  logic signed [16:0]   step_q;
  logic [15:0]          prev_phase_q;

  logic                 adv;
  logic                 issue;
  logic                 issue_last;
  logic                 in_xfer;
  logic                 chip_xfer;
  logic                 tap_wr;
  logic [AddrW-1:0]     tap_wr_addr;
  logic [CntW-1:0]      tap_count_ext;
  logic [CntW-1:0]      run_len;
  logic signed [17:0]   step_raw;
  logic signed [17:0]   step_wrap;

  logic signed [15:0]   tap_mem [MAX_TAPS];
  logic signed [15:0]   tap_rd_q;

  // Pipeline stages.
  logic                 s1_valid_q, s1_chip_end_q, s1_pulse_end_q;
  logic signed [16:0]   s1_step_q;
  logic                 s2_valid_q, s2_chip_end_q, s2_pulse_end_q;
  logic [31:0]          s2_inc_q;
  logic signed [32:0]   product;
  logic [31:0]          acc_q;
  logic [31:0]          acc_sum;
  logic                 s3_valid_q, s3_chip_end_q, s3_pulse_end_q;
  logic [11:0]          s3_angle_q;
  logic [9:0]           oct_pos;
  logic                 oct_swap;
  logic [pcfm_pkg::TRIG_ADDR_W-1:0] rom_addr;
  logic                 s4_valid_q, s4_chip_end_q, s4_pulse_end_q, s4_swap_q;
  logic [1:0]           s4_quad_q;
  logic [2*pcfm_pkg::MAG_W-1:0] rom_q;
  logic [pcfm_pkg::MAG_W-1:0]   cos_mag, sin_mag;
  logic signed [15:0]   cos_pos, sin_pos;
  logic                 out_valid_q;
  pcfm_pkg::out_item_t  out_d, out_q;

  // The whole pipeline moves together whenever the output register can take a sample.
  assign adv        = !out_valid_q || out_ready_i;
  assign issue      = busy_q && adv;
  assign issue_last = issue && (tap_idx_q == last_idx_q);
  assign in_ready_o = !busy_q || issue_last;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign chip_xfer  = in_xfer && (in_data_i.op == pcfm_pkg::OP_CHIP);
  assign tap_wr     = in_xfer && (in_data_i.op == pcfm_pkg::OP_TAP_WRITE)
                      && (32'(in_data_i.tap_index) < MAX_TAPS);
  assign tap_wr_addr = AddrW'(in_data_i.tap_index);
  assign cfg_ready_o = 1'b1;

  // A tap count of zero runs one tap; counts above the store depth run the whole store.
  assign tap_count_ext = CntW'(tap_count_q);
  always_comb begin
    if (tap_count_ext == '0) begin
      run_len = CntW'(1);
    end else if (32'(tap_count_ext) > MAX_TAPS) begin
      run_len = CntW'(MAX_TAPS);
    end else begin
      run_len = tap_count_ext;
    end
  end

  always_comb begin
    step_raw = $signed({2'b00, in_data_i.code_phase}) - $signed({2'b00, prev_phase_q});
    if (step_raw > 18'sd32768) begin
      step_wrap = step_raw - 18'sd65536;
    end else if (step_raw < -18'sd32768) begin
      step_wrap = step_raw + 18'sd65536;
    end else begin
      step_wrap = step_raw;
    end
  end

  always_comb begin
    busy_d    = busy_q;
    tap_idx_d = tap_idx_q;
    if (chip_xfer) begin
      busy_d    = 1'b1;
      tap_idx_d = '0;
    end else if (issue_last) begin
      busy_d = 1'b0;
    end else if (issue) begin
      tap_idx_d = tap_idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q  <= pcfm_pkg::TAP_COUNT_RST;
      busy_q       <= 1'b0;
      tap_idx_q    <= '0;
      prev_phase_q <= '0;
    end else begin
      busy_q    <= busy_d;
      tap_idx_q <= tap_idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= cfg_data_i;
      end
      if (chip_xfer) begin
        prev_phase_q <= in_data_i.last_chip ? 16'd0 : in_data_i.code_phase;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chip_xfer) begin
      step_q      <= step_wrap[16:0];
      last_idx_q  <= AddrW'(run_len - CntW'(1));
      last_chip_q <= in_data_i.last_chip;
    end
  end

  // Tap store: one write port from the input side, one registered read port for the sequencer.
  always_ff @(posedge clk_i) begin
    if (tap_wr) begin
      tap_mem[tap_wr_addr] <= in_data_i.tap_value;
    end
    if (adv) begin
      tap_rd_q <= tap_mem[tap_idx_q];
    end
  end

  assign product = s1_step_q * tap_rd_q;
  assign acc_sum = acc_q + s2_inc_q;

  // Fold the 12-bit angle into the first octant; past the octant, sine and cosine trade places.
  assign oct_pos  = s3_angle_q[9:0];
  assign oct_swap = oct_pos[9] && (oct_pos[8:0] != 9'd0);
  assign rom_addr = oct_swap ? pcfm_pkg::TRIG_ADDR_W'(11'd1024 - {1'b0, oct_pos}) : oct_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
      if (s2_valid_q) begin
        acc_q <= s2_pulse_end_q ? 32'd0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_step_q      <= step_q;
      s1_chip_end_q  <= (tap_idx_q == last_idx_q);
      s1_pulse_end_q <= (tap_idx_q == last_idx_q) && last_chip_q;

      s2_inc_q       <= {product[30:0], 1'b0};
      s2_chip_end_q  <= s1_chip_end_q;
      s2_pulse_end_q <= s1_pulse_end_q;

      s3_angle_q     <= acc_sum[31:20];
      s3_chip_end_q  <= s2_chip_end_q;
      s3_pulse_end_q <= s2_pulse_end_q;

      rom_q          <= TrigRom[rom_addr];
      s4_quad_q      <= s3_angle_q[11:10];
      s4_swap_q      <= oct_swap;
      s4_chip_end_q  <= s3_chip_end_q;
      s4_pulse_end_q <= s3_pulse_end_q;

      out_q          <= out_d;
    end
  end

  always_comb begin
    if (s4_swap_q) begin
      cos_mag = rom_q[pcfm_pkg::MAG_W-1:0];
      sin_mag = rom_q[2*pcfm_pkg::MAG_W-1:pcfm_pkg::MAG_W];
    end else begin
      cos_mag = rom_q[2*pcfm_pkg::MAG_W-1:pcfm_pkg::MAG_W];
      sin_mag = rom_q[pcfm_pkg::MAG_W-1:0];
    end
    cos_pos = $signed({1'b0, cos_mag});
    sin_pos = $signed({1'b0, sin_mag});
    case (s4_quad_q)
      2'd0: begin
        out_d.in_phase   = cos_pos;
        out_d.quadrature = sin_pos;
      end
      2'd1: begin
        out_d.in_phase   = -sin_pos;
        out_d.quadrature = cos_pos;
      end
      2'd2: begin
        out_d.in_phase   = -cos_pos;
        out_d.quadrature = -sin_pos;
      end
      default: begin
        out_d.in_phase   = sin_pos;
        out_d.quadrature = -cos_pos;
      end
    endcase
    out_d.last_of_chip  = s4_chip_end_q;
    out_d.last_of_pulse = s4_pulse_end_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/pcfm_sva_checker.sv @@
module pcfm_sva_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pcfm_pkg::out_item_t out_data_o
);

  // A sample that is held back must stay on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output sample changed while stalled");

  // The end of a pulse is always also the end of a chip's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_pulse |-> out_data_o.last_of_chip)
    else $error("pulse end without chip end");

  // Both components are scaled by 32767, so the most negative code never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.in_phase != -16'sd32768)
                    && (out_data_o.quadrature != -16'sd32768))
    else $error("sample outside the scaled range");

endmodule

bind pcfm_waveform_generator_unit pcfm_sva_checker u_pcfm_sva_checker (.*);

@@ bench/pcfm_sample_checker.sv @@
`timescale 1ns / 1ps

module pcfm_sample_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  pcfm_pkg::in_item_t               in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  pcfm_pkg::out_item_t              out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [pcfm_pkg::TAP_COUNT_W-1:0] cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam logic [63:0] UNITY_FX = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_FX    = 64'h3243_F6A8_885A_308D;
  localparam int          OCTANT_N = 512;

  logic [14:0]                      cos_mag [0:OCTANT_N];
  logic [14:0]                      sin_mag [0:OCTANT_N];
  logic [15:0]                      tap_coef [pcfm_pkg::MAX_TAPS_DEF];
  logic [15:0]                      prev_phase;
  logic [31:0]                      phase_acc;
  logic [pcfm_pkg::TAP_COUNT_W-1:0] tap_count;
  pcfm_pkg::out_item_t              expected_samples [$];
  int                               fail_count = 0;
  int                               pending_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  // Product of two Q60 numbers, kept in Q60.
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return 64'(wide >> 60);
  endfunction

  // Q60 magnitude to 32767 scale, rounded half up.
  function automatic logic [14:0] to_q15(input logic [63:0] v);
    logic [63:0] scaled;
    scaled = (v >> 20) * 64'd32767 + (64'd1 << 39);
    return 15'(scaled >> 40);
  endfunction

  initial begin : build_octant
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term_c;
    logic [63:0] term_s;
    logic [63:0] sum_c;
    logic [63:0] sum_s;
    for (int r = 0; r <= OCTANT_N; r++) begin
      x = (PI_FX / 2048) * 64'(r) + ((PI_FX % 2048) * 64'(r)) / 2048;
      x2 = fx_mul(x, x);
      term_c = UNITY_FX;
      term_s = x;
      sum_c = UNITY_FX;
      sum_s = x;
      for (int k = 1; k <= 14; k++) begin
        term_c = fx_mul(term_c, x2) / 64'((2 * k - 1) * (2 * k));
        term_s = fx_mul(term_s, x2) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum_c = sum_c - term_c;
          sum_s = sum_s - term_s;
        end else begin
          sum_c = sum_c + term_c;
          sum_s = sum_s + term_s;
        end
      end
      cos_mag[r] = to_q15(sum_c);
      sin_mag[r] = to_q15(sum_s);
    end
  end

  // The top two accumulator bits pick the quadrant; within a quadrant the upper
  // octant is the mirror of the lower one with sine and cosine swapped.
  function automatic pcfm_pkg::out_item_t sample_at(input logic [31:0] acc,
                                                    input logic chip_end,
                                                    input logic pulse_end);
    pcfm_pkg::out_item_t s;
    logic [9:0]          r;
    logic signed [15:0]  c_val;
    logic signed [15:0]  s_val;
    r = acc[29:20];
    if (r <= 10'(OCTANT_N)) begin
      c_val = {1'b0, cos_mag[r]};
      s_val = {1'b0, sin_mag[r]};
    end else begin
      c_val = {1'b0, sin_mag[1024 - int'(r)]};
      s_val = {1'b0, cos_mag[1024 - int'(r)]};
    end
    case (acc[31:30])
      2'd0: begin
        s.in_phase = c_val;
        s.quadrature = s_val;
      end
      2'd1: begin
        s.in_phase = -s_val;
        s.quadrature = c_val;
      end
      2'd2: begin
        s.in_phase = -c_val;
        s.quadrature = -s_val;
      end
      default: begin
        s.in_phase = s_val;
        s.quadrature = -c_val;
      end
    endcase
    s.last_of_chip = chip_end;
    s.last_of_pulse = pulse_end;
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pcfm_pkg::out_item_t want;
    int                  n_samples;
    int                  step;
    longint              coef;
    logic [63:0]         incr;
    logic                chip_end;
    if (!rst_ni) begin
      prev_phase = '0;
      phase_acc = '0;
      tap_count = pcfm_pkg::TAP_COUNT_RST;
      expected_samples.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample with none expected: in_phase %0d quadrature %0d",
                 out_data_i.in_phase, out_data_i.quadrature);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data_i.in_phase !== want.in_phase) begin
            $error("in_phase: expected %0d, got %0d", want.in_phase, out_data_i.in_phase);
            fail_count++;
          end
          if (out_data_i.quadrature !== want.quadrature) begin
            $error("quadrature: expected %0d, got %0d", want.quadrature,
                   out_data_i.quadrature);
            fail_count++;
          end
          if (out_data_i.last_of_chip !== want.last_of_chip) begin
            $error("last_of_chip: expected %0b, got %0b", want.last_of_chip,
                   out_data_i.last_of_chip);
            fail_count++;
          end
          if (out_data_i.last_of_pulse !== want.last_of_pulse) begin
            $error("last_of_pulse: expected %0b, got %0b", want.last_of_pulse,
                   out_data_i.last_of_pulse);
            fail_count++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        tap_count = cfg_data_i;
      end

      if (in_valid_i && in_ready_i) begin
        if (in_data_i.op == pcfm_pkg::OP_TAP_WRITE) begin
          tap_coef[in_data_i.tap_index] = in_data_i.tap_value;
        end else begin
          n_samples = int'(tap_count);
          if (n_samples < 1) n_samples = 1;
          if (n_samples > pcfm_pkg::MAX_TAPS_DEF) n_samples = pcfm_pkg::MAX_TAPS_DEF;
          // Phase step between chips, folded into one half turn either way.
          step = int'(in_data_i.code_phase) - int'(prev_phase);
          if (step > 32768) step = step - 65536;
          else if (step < -32768) step = step + 65536;
          for (int j = 0; j < n_samples; j++) begin
            coef = longint'($signed(tap_coef[j]));
            incr = 64'(2 * longint'(step) * coef);
            phase_acc = phase_acc + incr[31:0];
            chip_end = (j == n_samples - 1);
            expected_samples.push_back(sample_at(phase_acc, chip_end,
                                                 chip_end && in_data_i.last_chip));
          end
          if (in_data_i.last_chip) begin
            prev_phase = '0;
            phase_acc = '0;
          end else begin
            prev_phase = in_data_i.code_phase;
          end
        end
      end
    end
    pending_count = expected_samples.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int CHIPS_PER_PHASE = 20;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  pcfm_pkg::in_item_t               in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  pcfm_pkg::out_item_t              out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [pcfm_pkg::TAP_COUNT_W-1:0] cfg_data = '0;

  int          send_idle_pct = 18;
  int          recv_idle_pct = 49;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic [15:0] last_sent_phase = '0;

  pcfm_waveform_generator_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  pcfm_sample_checker sample_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pcfm_waveform_generator_unit verification failed");
      $finish;
    end
  end

  function automatic pcfm_pkg::in_item_t tap_item(input logic [4:0] idx,
                                                  input logic [15:0] val);
    pcfm_pkg::in_item_t it;
    it.op = pcfm_pkg::OP_TAP_WRITE;
    it.tap_index = idx;
    it.tap_value = val;
    it.code_phase = 16'($urandom);
    it.last_chip = 1'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] next_phase();
    case ($urandom_range(4))
      0, 1: return 16'($urandom);
      // Lands right at the half-turn wrap boundary.
      2: return last_sent_phase + 16'd32768 + 16'($urandom_range(4)) - 16'd2;
      3: return last_sent_phase + 16'($urandom_range(128)) - 16'd64;
      default: begin
        case ($urandom_range(3))
          0: return 16'h0000;
          1: return 16'h7FFF;
          2: return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays up if the next transfer follows at once.
  task automatic push_item(input pcfm_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_chip(input logic [15:0] phase, input logic last);
    pcfm_pkg::in_item_t it;
    it.op = pcfm_pkg::OP_CHIP;
    it.tap_index = 5'($urandom);
    it.tap_value = 16'($urandom);
    it.code_phase = phase;
    it.last_chip = last;
    push_item(it);
    last_sent_phase = last ? 16'h0000 : phase;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_tap_count(input logic [pcfm_pkg::TAP_COUNT_W-1:0] count);
    hold_until_drained();
    // A tap write just ahead may still be in the pipeline with nothing to show for it.
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pulses(input int chips);
    int sent;
    int pulse_len;
    sent = 0;
    while (sent < chips) begin
      pulse_len = $urandom_range(1, 6);
      for (int c = 0; c < pulse_len; c++) begin
        if ($urandom_range(7) == 0) begin
          push_item(tap_item(5'($urandom), 16'($urandom)));
        end
        // Now and then a pulse is left open and runs into the next one.
        send_chip(next_phase(), (c == pulse_len - 1) && ($urandom_range(9) != 0));
        sent++;
      end
      if ($urandom_range(30) == 0) hold_until_drained();
    end
  endtask

  initial begin
    logic [pcfm_pkg::TAP_COUNT_W-1:0] count_plan [PHASES];
    count_plan = '{6'd1, 6'd0, 6'd63, 6'd7, 6'd33, 6'd32, 6'd20, 6'd16};
    count_plan[6] = pcfm_pkg::TAP_COUNT_W'($urandom_range(2, 31));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every tap is loaded before the first chip reads it.
    for (int i = 0; i < pcfm_pkg::MAX_TAPS_DEF; i++) begin
      push_item(tap_item(5'(i), 16'($urandom)));
    end

    push_item(tap_item(5'd0, 16'h7FFF));
    push_item(tap_item(5'd31, 16'h8000));
    send_chip(16'd0, 1'b0);
    send_chip(16'd32768, 1'b0);
    send_chip(16'd65535, 1'b0);
    send_chip(16'd0, 1'b0);
    send_chip(16'd32769, 1'b0);
    send_chip(16'd0, 1'b0);
    send_chip(16'd32768, 1'b0);
    send_chip(16'd0, 1'b1);
    send_chip(16'd65535, 1'b1);
    send_chip(16'd12345, 1'b0);
    send_chip(16'd40000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 49;
      end else if (p < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_tap_count(count_plan[p]);
      random_pulses(CHIPS_PER_PHASE);
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("pcfm_waveform_generator_unit verification clean");
    end else begin
      $display("pcfm_waveform_generator_unit verification failed");
    end
    $finish;
  end

endmodule
